>>> hdl/soa_pkg.sv
// soa_pkg: shared constants, codes and record type of the slab object allocator
// no dependencies; used by the interfaces, the top level and the checker
`timescale 1ns / 1ps
`default_nettype none
package soa_pkg;

  localparam int unsigned MaxSlabs  = 16;
  localparam int unsigned MaxSlots  = 64;
  localparam int unsigned SLAB_W    = $clog2(MaxSlabs);
  localparam int unsigned SLOT_W    = $clog2(MaxSlots);
  localparam int unsigned SLABX_W   = SLAB_W + 1;   // slab index plus nil
  localparam int unsigned SLOTX_W   = SLOT_W + 1;   // slot index plus nil
  localparam int unsigned SLOTA_W   = SLAB_W + SLOT_W;
  localparam int unsigned OPCODE_W  = 2;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned ACTIVE_W  = 11;
  localparam int unsigned NumClass  = 3;

  localparam logic [SLABX_W-1:0] NIL_SLAB = SLABX_W'(MaxSlabs);
  localparam logic [SLOTX_W-1:0] NIL_SLOT = SLOTX_W'(MaxSlots);

  localparam logic [OPCODE_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_FREE    = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_DESTROY = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SLABS  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOREIGN   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SLAB_IDLE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ACTIVE    = 3'd4;

  localparam logic [1:0] CLS_FULL    = 2'd0;
  localparam logic [1:0] CLS_PARTIAL = 2'd1;
  localparam logic [1:0] CLS_EMPTY   = 2'd2;

  typedef struct packed {
    logic [SLABX_W-1:0] prev;
    logic [SLABX_W-1:0] next;
    logic [SLOTX_W-1:0] top;
    logic [SLOTX_W-1:0] use_cnt;
  } slab_rec_t;

endpackage
`default_nettype wire

>>> hdl/soa_if.sv
// soa_req_if / soa_rsp_if: valid-ready channels of the slab object allocator
// depends on soa_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none
interface soa_req_if;
  logic                          valid;
  logic                          ready;
  logic [soa_pkg::OPCODE_W-1:0]  opcode;
  logic                          handle_null;
  logic [soa_pkg::SLAB_W-1:0]    free_slab;
  logic [soa_pkg::SLOT_W-1:0]    free_slot;
  modport source (output valid, opcode, handle_null, free_slab, free_slot, input ready);
  modport sink (input valid, opcode, handle_null, free_slab, free_slot, output ready);
endinterface

interface soa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [soa_pkg::STATUS_W-1:0]  status;
  logic [soa_pkg::SLAB_W-1:0]    out_slab;
  logic [soa_pkg::SLOT_W-1:0]    out_slot;
  logic [soa_pkg::ACTIVE_W-1:0]  active_count;
  modport source (output valid, status, out_slab, out_slot, active_count, input ready);
  modport sink (input valid, status, out_slab, out_slot, active_count, output ready);
endinterface
`default_nettype wire

>>> hdl/slab_object_allocator_unit.sv
// slab_object_allocator_unit: sequencer over slab record and slot link rams
// depends on soa_pkg, soa_req_if, soa_rsp_if and soa_ram
`timescale 1ns / 1ps
`default_nettype none

// One operation is taken at a time and its single result is held in an output
// register, so the next operation is accepted while a result waits. The steps
// access the slab record ram and the slot link ram, each with a registered
// read. A free and an allocate from an existing slab run a chain of record
// read-modify-writes that unlinks the slab and appends it to its new list; a
// neighbor or an old tail adds steps to that chain. An allocate that grows a
// new slab seeds its free-slot stack, one slot link per cycle, then pops its
// first slot. Destroy, null frees, foreign frees, out-of-slab allocates and
// unused opcodes go straight to the result, and a free to an idle slab or an
// allocate from a dry stack stops after reading the slab record. The result
// waits in the sequencer while the output register still holds an untaken
// transfer, and ready returns in the cycle after the result is loaded.
module slab_object_allocator_unit (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [soa_pkg::CFG_W-1:0] cfg_wdata_i,
  soa_req_if.sink                        req,
  soa_rsp_if.source                      rsp
);
  import soa_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_SEED  = 4'd2;
  localparam logic [3:0] S_AREC  = 4'd3;
  localparam logic [3:0] S_ASLOT = 4'd4;
  localparam logic [3:0] S_APOP  = 4'd5;
  localparam logic [3:0] S_FREC  = 4'd6;
  localparam logic [3:0] S_ULP   = 4'd7;
  localparam logic [3:0] S_ULPW  = 4'd8;
  localparam logic [3:0] S_ULN   = 4'd9;
  localparam logic [3:0] S_ULNW  = 4'd10;
  localparam logic [3:0] S_APND  = 4'd11;
  localparam logic [3:0] S_APTW  = 4'd12;
  localparam logic [3:0] S_RESP  = 4'd13;

  logic [3:0]          state_q, state_d;
  logic [CFG_W-1:0]    objs_q;
  logic [SLOTX_W-1:0]  eff_n;

  logic [OPCODE_W-1:0] op_q, op_d;
  logic                hnull_q, hnull_d;
  logic [SLAB_W-1:0]   fslab_q, fslab_d;
  logic [SLOT_W-1:0]   fslot_q, fslot_d;
  logic [SLAB_W-1:0]   s_q, s_d;
  slab_rec_t           rec_q, rec_d;
  logic [1:0]          cls_q, cls_d;
  logic                fresh_q, fresh_d;
  logic [SLOT_W-1:0]   idx_q, idx_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [SLAB_W-1:0]   oslab_q, oslab_d;
  logic [SLOT_W-1:0]   oslot_q, oslot_d;
  logic [SLABX_W-1:0]  grown_q, grown_d;
  logic [ACTIVE_W-1:0] active_q, active_d;
  logic [SLABX_W-1:0]  head_q [NumClass];
  logic [SLABX_W-1:0]  head_d [NumClass];
  logic [SLABX_W-1:0]  tail_q [NumClass];
  logic [SLABX_W-1:0]  tail_d [NumClass];

  logic                ovalid_q, ovalid_d;
  logic [STATUS_W-1:0] ost_q;
  logic [SLAB_W-1:0]   oslab_out_q;
  logic [SLOT_W-1:0]   oslot_out_q;
  logic [ACTIVE_W-1:0] oact_q;
  logic                load_out;

  logic                rec_we;
  logic [SLAB_W-1:0]   rec_waddr, rec_raddr;
  slab_rec_t           rec_wdata, rec_rdata;
  logic                slot_we;
  logic [SLOTA_W-1:0]  slot_waddr, slot_raddr;
  logic [SLOTX_W-1:0]  slot_wdata, slot_rdata;
  logic [SLOTX_W-1:0]  use_inc;
  logic [SLABX_W-1:0]  tail_sel;

  soa_ram #(.Width($bits(slab_rec_t)), .Depth(MaxSlabs)) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (rec_waddr),
    .wdata_i (rec_wdata),
    .raddr_i (rec_raddr),
    .rdata_o (rec_rdata)
  );

  soa_ram #(.Width(SLOTX_W), .Depth(MaxSlabs * MaxSlots)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  // effective slots per slab, clamped to 1..MaxSlots
  always_comb begin
    if (objs_q == '0) begin
      eff_n = SLOTX_W'(1);
    end else if (SLOTX_W'(objs_q) > SLOTX_W'(MaxSlots) || objs_q > CFG_W'(MaxSlots)) begin
      eff_n = SLOTX_W'(MaxSlots);
    end else begin
      eff_n = SLOTX_W'(objs_q);
    end
  end

  assign req.ready        = (state_q == S_IDLE);
  assign rsp.valid        = ovalid_q;
  assign rsp.status       = ost_q;
  assign rsp.out_slab     = oslab_out_q;
  assign rsp.out_slot     = oslot_out_q;
  assign rsp.active_count = oact_q;

  assign use_inc  = rec_q.use_cnt + SLOTX_W'(1);
  assign tail_sel = tail_q[cls_q];

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    hnull_d    = hnull_q;
    fslab_d    = fslab_q;
    fslot_d    = fslot_q;
    s_d        = s_q;
    rec_d      = rec_q;
    cls_d      = cls_q;
    fresh_d    = fresh_q;
    idx_d      = idx_q;
    status_d   = status_q;
    oslab_d    = oslab_q;
    oslot_d    = oslot_q;
    grown_d    = grown_q;
    active_d   = active_q;
    head_d     = head_q;
    tail_d     = tail_q;
    load_out   = 1'b0;
    rec_we     = 1'b0;
    rec_waddr  = s_q;
    rec_wdata  = rec_q;
    rec_raddr  = s_q;
    slot_we    = 1'b0;
    slot_waddr = {s_q, idx_q};
    slot_wdata = NIL_SLOT;
    slot_raddr = {s_q, rec_q.top[SLOT_W-1:0]};

    unique case (state_q)
      S_IDLE: begin
        if (req.valid) begin
          op_d     = req.opcode;
          hnull_d  = req.handle_null;
          fslab_d  = req.free_slab;
          fslot_d  = req.free_slot;
          status_d = ST_OK;
          oslab_d  = '0;
          oslot_d  = '0;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_RESP;
        unique case (op_q)
          OP_ALLOC: begin
            if (!head_q[CLS_PARTIAL][SLAB_W]) begin
              s_d       = head_q[CLS_PARTIAL][SLAB_W-1:0];
              rec_raddr = head_q[CLS_PARTIAL][SLAB_W-1:0];
              state_d   = S_AREC;
            end else if (!head_q[CLS_EMPTY][SLAB_W]) begin
              s_d       = head_q[CLS_EMPTY][SLAB_W-1:0];
              rec_raddr = head_q[CLS_EMPTY][SLAB_W-1:0];
              state_d   = S_AREC;
            end else if (!grown_q[SLAB_W]) begin
              s_d     = grown_q[SLAB_W-1:0];
              idx_d   = '0;
              state_d = S_SEED;
            end else begin
              status_d = ST_NO_SLABS;
            end
          end
          OP_FREE: begin
            if (hnull_q) begin
              status_d = ST_OK;
            end else if ({1'b0, fslab_q} >= grown_q) begin
              status_d = ST_FOREIGN;
            end else begin
              s_d       = fslab_q;
              rec_raddr = fslab_q;
              state_d   = S_FREC;
            end
          end
          OP_DESTROY: begin
            if (active_q != '0) begin
              status_d = ST_ACTIVE;
            end else begin
              for (int c = 0; c < NumClass; c++) begin
                head_d[c] = NIL_SLAB;
                tail_d[c] = NIL_SLAB;
              end
              grown_d = '0;
            end
          end
          default: begin
            status_d = ST_OK;
          end
        endcase
      end
      S_SEED: begin
        // slot 0 ends the stack, every other slot links to the one below
        slot_we    = 1'b1;
        slot_waddr = {s_q, idx_q};
        slot_wdata = (idx_q == '0) ? NIL_SLOT : {1'b0, idx_q - SLOT_W'(1)};
        idx_d      = idx_q + SLOT_W'(1);
        if ({1'b0, idx_q} == eff_n - SLOTX_W'(1)) begin
          rec_d.prev    = NIL_SLAB;
          rec_d.next    = NIL_SLAB;
          rec_d.top     = eff_n - SLOTX_W'(1);
          rec_d.use_cnt = '0;
          grown_d       = grown_q + SLABX_W'(1);
          fresh_d       = 1'b1;
          state_d       = S_ASLOT;
        end
      end
      S_AREC: begin
        rec_d   = rec_rdata;
        fresh_d = 1'b0;
        if (rec_rdata.top[SLOT_W]) begin
          status_d = ST_NO_SLABS;
          state_d  = S_RESP;
        end else begin
          state_d = S_ASLOT;
        end
      end
      S_ASLOT: begin
        slot_raddr = {s_q, rec_q.top[SLOT_W-1:0]};
        state_d    = S_APOP;
      end
      S_APOP: begin
        oslab_d       = s_q;
        oslot_d       = rec_q.top[SLOT_W-1:0];
        rec_d.top     = slot_rdata;
        rec_d.use_cnt = use_inc;
        active_d      = active_q + ACTIVE_W'(1);
        cls_d         = (use_inc >= eff_n || slot_rdata[SLOT_W]) ? CLS_FULL : CLS_PARTIAL;
        // a freshly grown slab sits on no list yet
        state_d       = fresh_q ? S_APND : S_ULP;
      end
      S_FREC: begin
        rec_d = rec_rdata;
        if (rec_rdata.use_cnt == '0) begin
          status_d = ST_SLAB_IDLE;
          state_d  = S_RESP;
        end else begin
          slot_we       = 1'b1;
          slot_waddr    = {s_q, fslot_q};
          slot_wdata    = rec_rdata.top;
          rec_d.top     = {1'b0, fslot_q};
          rec_d.use_cnt = rec_rdata.use_cnt - SLOTX_W'(1);
          active_d      = active_q - ACTIVE_W'(1);
          cls_d         = (rec_rdata.use_cnt == SLOTX_W'(1)) ? CLS_EMPTY : CLS_PARTIAL;
          state_d       = S_ULP;
        end
      end
      S_ULP: begin
        if (!rec_q.prev[SLAB_W]) begin
          rec_raddr = rec_q.prev[SLAB_W-1:0];
          state_d   = S_ULPW;
        end else begin
          for (int c = 0; c < NumClass; c++) begin
            if (head_q[c] == {1'b0, s_q}) head_d[c] = rec_q.next;
          end
          state_d = S_ULN;
        end
      end
      S_ULPW: begin
        rec_we         = 1'b1;
        rec_waddr      = rec_q.prev[SLAB_W-1:0];
        rec_wdata      = rec_rdata;
        rec_wdata.next = rec_q.next;
        state_d        = S_ULN;
      end
      S_ULN: begin
        if (!rec_q.next[SLAB_W]) begin
          rec_raddr = rec_q.next[SLAB_W-1:0];
          state_d   = S_ULNW;
        end else begin
          for (int c = 0; c < NumClass; c++) begin
            if (tail_q[c] == {1'b0, s_q}) tail_d[c] = rec_q.prev;
          end
          state_d = S_APND;
        end
      end
      S_ULNW: begin
        rec_we         = 1'b1;
        rec_waddr      = rec_q.next[SLAB_W-1:0];
        rec_wdata      = rec_rdata;
        rec_wdata.prev = rec_q.prev;
        state_d        = S_APND;
      end
      S_APND: begin
        rec_we         = 1'b1;
        rec_waddr      = s_q;
        rec_wdata      = rec_q;
        rec_wdata.prev = tail_sel;
        rec_wdata.next = NIL_SLAB;
        if (!tail_sel[SLAB_W]) begin
          rec_raddr = tail_sel[SLAB_W-1:0];
          state_d   = S_APTW;
        end else begin
          head_d[cls_q] = {1'b0, s_q};
          tail_d[cls_q] = {1'b0, s_q};
          state_d       = S_RESP;
        end
      end
      S_APTW: begin
        rec_we         = 1'b1;
        rec_waddr      = tail_sel[SLAB_W-1:0];
        rec_wdata      = rec_rdata;
        rec_wdata.next = {1'b0, s_q};
        tail_d[cls_q]  = {1'b0, s_q};
        state_d        = S_RESP;
      end
      S_RESP: begin
        if (!ovalid_q || rsp.ready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (rsp.valid && rsp.ready) ovalid_d = 1'b0;
    if (load_out) ovalid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      objs_q   <= CFG_W'(MaxSlots);
      grown_q  <= '0;
      active_q <= '0;
      ovalid_q <= 1'b0;
      for (int c = 0; c < NumClass; c++) begin
        head_q[c] <= NIL_SLAB;
        tail_q[c] <= NIL_SLAB;
      end
    end else begin
      state_q  <= state_d;
      grown_q  <= grown_d;
      active_q <= active_d;
      ovalid_q <= ovalid_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      if (cfg_we_i) objs_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    hnull_q  <= hnull_d;
    fslab_q  <= fslab_d;
    fslot_q  <= fslot_d;
    s_q      <= s_d;
    rec_q    <= rec_d;
    cls_q    <= cls_d;
    fresh_q  <= fresh_d;
    idx_q    <= idx_d;
    status_q <= status_d;
    oslab_q  <= oslab_d;
    oslot_q  <= oslot_d;
    if (load_out) begin
      ost_q       <= status_q;
      oslab_out_q <= oslab_q;
      oslot_out_q <= oslot_q;
      oact_q      <= active_q;
    end
  end
endmodule
`default_nettype wire

>>> hdl/soa_ram.sv
// soa_ram: simple dual-port synchronous ram, one write and one registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module soa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> hdl/soa_checker.sv
// soa_checker: port-level assertions on the slab object allocator result channel
// depends on soa_pkg; bound to slab_object_allocator_unit at the end of this file
`timescale 1ns / 1ps
`default_nettype none
module soa_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         valid_i,
  input wire logic                         ready_i,
  input wire logic [soa_pkg::STATUS_W-1:0] status_i,
  input wire logic [soa_pkg::SLAB_W-1:0]   slab_i,
  input wire logic [soa_pkg::SLOT_W-1:0]   slot_i,
  input wire logic [soa_pkg::ACTIVE_W-1:0] active_i
);
  import soa_pkg::*;

  // a stalled result stays up
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i)
    else $error("result dropped while stalled");

  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> $stable(status_i) && $stable(active_i))
    else $error("stalled result changed");

  // failed operations report no object
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && status_i != ST_OK |-> slab_i == '0 && slot_i == '0)
    else $error("failed operation reports an object");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> status_i <= ST_ACTIVE)
    else $error("status code out of range");

  a_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> active_i <= ACTIVE_W'(MaxSlabs * MaxSlots))
    else $error("active count beyond pool size");
endmodule

bind slab_object_allocator_unit soa_checker u_soa_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .valid_i  (rsp.valid),
  .ready_i  (rsp.ready),
  .status_i (rsp.status),
  .slab_i   (rsp.out_slab),
  .slot_i   (rsp.out_slot),
  .active_i (rsp.active_count)
);
`default_nettype wire
